// ===== rtl/core/lr_config_token_parser_assert.svh =====
// ----------------------------------------------------------------------------
// lr_config_token_parser_assert.svh
// Assertion macros for the configuration token parser.
// ----------------------------------------------------------------------------
`ifndef LR_CONFIG_TOKEN_PARSER_ASSERT_SVH
`define LR_CONFIG_TOKEN_PARSER_ASSERT_SVH

`ifndef ASSERT_OFF
// Check that a condition implies a consequence in the same cycle
`define LRCP_ASSERT_IMPL(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
// Check that a condition implies a consequence in the next cycle
`define LRCP_ASSERT_NEXT(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define LRCP_ASSERT_IMPL(name, ante, cons, msg)
`define LRCP_ASSERT_NEXT(name, ante, cons, msg)
`endif

`endif

// ===== rtl/core/lrcp_pkg.sv =====
// ----------------------------------------------------------------------------
// lrcp_pkg
// Types, constants and parse tables of the configuration token parser.
// ----------------------------------------------------------------------------
package lrcp_pkg;

	localparam int STACK_DEPTH = 64;
	localparam int SP_W        = $clog2(STACK_DEPTH + 1);
	localparam int ADDR_W      = $clog2(STACK_DEPTH);
	localparam int ST_W        = 4;
	localparam int MAX_RED     = 8;
	localparam int RED_W       = $clog2(MAX_RED + 1);

	typedef enum logic [2:0] {
		TK_EOF  = 3'd0,
		TK_ID   = 3'd1,
		TK_EQ   = 3'd2,
		TK_LB   = 3'd3,
		TK_RB   = 3'd4,
		TK_SEMI = 3'd5,
		TK_INT  = 3'd6,
		TK_STR  = 3'd7
	} tok_kind_t;

	typedef enum logic [2:0] {
		EV_NONE     = 3'd0,
		EV_ENTER    = 3'd1,
		EV_LEAVE    = 3'd2,
		EV_ADD      = 3'd3,
		EV_ACCEPT   = 3'd4,
		EV_SYNTAX   = 3'd5,
		EV_OVERFLOW = 3'd6
	} evt_kind_t;

	typedef struct packed {
		logic [2:0]  token_kind;
		logic [15:0] token_value;
	} tok_t;

	typedef struct packed {
		logic [2:0]  event_kind;
		logic [15:0] key_handle;
		logic [15:0] value_handle;
	} evt_t;

	// Table lookup result: hit flag plus a state or rule number
	typedef struct packed {
		logic            hit;
		logic [ST_W-1:0] val;
	} lkp_t;

	localparam logic [ST_W-1:0] ST_ACCEPT = 4'd1;

	// Shift action for a state and token
	function automatic lkp_t shift_to(logic [ST_W-1:0] st, logic [2:0] tk);
		lkp_t r;
		r = '{hit: 1'b0, val: '0};
		case (st)
			4'd1: if (tk == TK_ID) r = '{1'b1, 4'd2};
			4'd2: begin
				if (tk == TK_EQ) r = '{1'b1, 4'd4};
				else if (tk == TK_LB) r = '{1'b1, 4'd5};
			end
			4'd4: begin
				if (tk == TK_INT) r = '{1'b1, 4'd7};
				else if (tk == TK_STR) r = '{1'b1, 4'd8};
			end
			4'd6: if (tk == TK_SEMI) r = '{1'b1, 4'd10};
			4'd9: begin
				if (tk == TK_RB) r = '{1'b1, 4'd11};
				else if (tk == TK_ID) r = '{1'b1, 4'd2};
			end
			default: r = '{hit: 1'b0, val: '0};
		endcase
		return r;
	endfunction

	// Reduce action: rule number for a state and lookahead token
	function automatic lkp_t reduce_by(logic [ST_W-1:0] st, logic [2:0] tk);
		lkp_t r;
		logic end_set;
		r = '{hit: 1'b0, val: '0};
		end_set = (tk == TK_EOF) || (tk == TK_RB) || (tk == TK_ID);
		case (st)
			4'd0:  if (tk == TK_EOF || tk == TK_ID) r = '{1'b1, 4'd2};
			4'd3:  if (end_set) r = '{1'b1, 4'd1};
			4'd5:  if (tk == TK_RB || tk == TK_ID) r = '{1'b1, 4'd2};
			4'd7:  if (tk == TK_SEMI) r = '{1'b1, 4'd5};
			4'd8:  if (tk == TK_SEMI) r = '{1'b1, 4'd6};
			4'd10: if (end_set) r = '{1'b1, 4'd3};
			4'd11: if (end_set) r = '{1'b1, 4'd4};
			default: r = '{hit: 1'b0, val: '0};
		endcase
		return r;
	endfunction

	// Goto state after a reduction, from the uncovered state
	function automatic lkp_t goto_after(logic [ST_W-1:0] st, logic [ST_W-1:0] rule);
		lkp_t r;
		r = '{hit: 1'b0, val: '0};
		case (st)
			4'd0: if (rule == 4'd1 || rule == 4'd2) r = '{1'b1, 4'd1};
			4'd2: if (rule == 4'd3 || rule == 4'd4) r = '{1'b1, 4'd3};
			4'd4: if (rule == 4'd5 || rule == 4'd6) r = '{1'b1, 4'd6};
			4'd5: if (rule == 4'd1 || rule == 4'd2) r = '{1'b1, 4'd9};
			default: r = '{hit: 1'b0, val: '0};
		endcase
		return r;
	endfunction

	// Number of states popped by a rule
	function automatic logic [1:0] rule_pops(logic [ST_W-1:0] rule);
		logic [1:0] k;
		case (rule)
			4'd1, 4'd3, 4'd4: k = 2'd3;
			4'd5, 4'd6:       k = 2'd1;
			default:          k = 2'd0;
		endcase
		return k;
	endfunction

endpackage

// ===== rtl/core/lrcp_ram.sv =====
// ----------------------------------------------------------------------------
// lrcp_ram
// Generic single-write, single-read synchronous RAM with registered read.
// ----------------------------------------------------------------------------
module lrcp_ram #(
	parameter int WIDTH = 4,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write and registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== rtl/core/lr_config_token_parser.sv =====
// ----------------------------------------------------------------------------
// lr_config_token_parser
// Table-driven shift/reduce parser for a nested key/value configuration
// grammar, one event per token, parse stack held in a synchronous RAM.
// ----------------------------------------------------------------------------
// Usage:
//   Tokens enter on tok (kind and value handle) under tok_valid/tok_stall;
//   one event leaves on evt under evt_valid/evt_stall for every token.
//   A token is taken only when the parser is idle; tok_stall is high while
//   a token is being worked on.
//   Each token is evaluated; each reduction adds an evaluate step, then a
//   goto step with a stack RAM read. The grammar needs at most two
//   reductions per token. The evaluate/goto loop around the stack RAM read
//   sets how long a token takes.
//   A finished event sits in an output register; the next token may be taken
//   while it waits. When evt_stall holds that register full, the parser
//   waits before finishing the next token.
//   Reset leaves one stack entry (state 0) in use and clears the stored
//   identifier. Accept and any error event put the parser back in that state.
//   Stack entry zero is never written and reads as state 0, so the RAM
//   needs no clearing pass.
// ----------------------------------------------------------------------------
module lr_config_token_parser
	import lrcp_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic tok_valid,
	output logic tok_stall,
	input  tok_t tok,
	output logic evt_valid,
	input  logic evt_stall,
	output evt_t evt
);

	`include "lr_config_token_parser_assert.svh"

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_EVAL = 3'b010,
		ST_GOTO = 3'b100
	} state_t;

	state_t            state_q;
	logic [SP_W-1:0]   sp_q;
	logic [ST_W-1:0]   top_q;
	logic [15:0]       last_id_q;
	logic [RED_W-1:0]  red_cnt_q;
	tok_t              tok_q;
	logic [ST_W-1:0]   rule_q;
	logic              popped_q;
	logic              rd_zero_q;
	logic              evt_valid_q;
	evt_t              evt_q;

	logic              out_free;
	logic              in_accept;
	lkp_t              sh;
	lkp_t              rd;
	lkp_t              gt;
	logic [1:0]        pops;
	logic [SP_W-1:0]   sp_pop;
	logic [SP_W-1:0]   rd_ptr;
	logic [ST_W-1:0]   cur_st;
	logic              stack_full;
	logic              red_go;
	logic              gt_go;
	logic              evt_fire;
	evt_t              evt_next;

	logic              ram_we;
	logic [ADDR_W-1:0] ram_waddr;
	logic [ST_W-1:0]   ram_wdata;
	logic              ram_re;
	logic [ST_W-1:0]   ram_rdata;

	assign in_accept  = tok_valid && !tok_stall;
	assign tok_stall  = (state_q != ST_IDLE);
	assign out_free   = !evt_valid_q || !evt_stall;
	assign evt_valid  = evt_valid_q;
	assign evt        = evt_q;
	assign stack_full = (sp_q == SP_W'(STACK_DEPTH));

	// Table lookups on the top state and held token
	assign sh     = shift_to(top_q, tok_q.token_kind);
	assign rd     = reduce_by(top_q, tok_q.token_kind);
	assign pops   = rule_pops(rd.val);
	assign sp_pop = sp_q - SP_W'(pops);
	assign rd_ptr = sp_pop - SP_W'(1);
	assign red_go = rd.hit && (red_cnt_q != RED_W'(MAX_RED)) && (sp_q > SP_W'(pops));

	// Uncovered state after a pop; entry zero always reads as state 0
	assign cur_st = popped_q ? (rd_zero_q ? '0 : ram_rdata) : top_q;
	assign gt     = goto_after(cur_st, rule_q);
	assign gt_go  = gt.hit && !stack_full;

	// Finish the request: shift, accept or fail in evaluate, fail in goto
	assign evt_fire = out_free && (((state_q == ST_EVAL) && (sh.hit || !red_go))
		|| ((state_q == ST_GOTO) && !gt_go));

	// Push the new state at the current stack pointer
	always_comb begin
		ram_we    = 1'b0;
		ram_wdata = sh.val;
		if (out_free) begin
			if (state_q == ST_EVAL && sh.hit && !stack_full) begin
				ram_we = 1'b1;
			end
			if (state_q == ST_GOTO && gt_go) begin
				ram_we    = 1'b1;
				ram_wdata = gt.val;
			end
		end
	end
	assign ram_waddr = sp_q[ADDR_W-1:0];
	assign ram_re    = (state_q == ST_EVAL) && out_free && !sh.hit && red_go
		&& (pops != 2'd0);

	lrcp_ram #(
		.WIDTH (ST_W),
		.DEPTH (STACK_DEPTH)
	) u_stack (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (rd_ptr[ADDR_W-1:0]),
		.rdata (ram_rdata)
	);

	// Build the event payload of a finishing request
	always_comb begin
		evt_next = '{event_kind: EV_SYNTAX, key_handle: '0, value_handle: '0};
		if (state_q == ST_EVAL) begin
			if (sh.hit) begin
				if (stack_full) begin
					evt_next.event_kind = EV_OVERFLOW;
				end else begin
					case (tok_q.token_kind)
						TK_INT, TK_STR: begin
							evt_next = '{event_kind: EV_ADD, key_handle: last_id_q,
								value_handle: tok_q.token_value};
						end
						TK_LB: begin
							evt_next = '{event_kind: EV_ENTER, key_handle: last_id_q,
								value_handle: '0};
						end
						TK_RB:   evt_next.event_kind = EV_LEAVE;
						default: evt_next.event_kind = EV_NONE;
					endcase
				end
			end else if (!rd.hit && top_q == ST_ACCEPT && tok_q.token_kind == TK_EOF) begin
				evt_next.event_kind = EV_ACCEPT;
			end
		end else if (state_q == ST_GOTO && gt.hit) begin
			evt_next.event_kind = EV_OVERFLOW;
		end
	end

	// Parser control: evaluate actions, pop, goto, emit events
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			sp_q        <= SP_W'(1);
			top_q       <= '0;
			last_id_q   <= '0;
			red_cnt_q   <= '0;
			popped_q    <= 1'b0;
			rd_zero_q   <= 1'b0;
			evt_valid_q <= 1'b0;
		end else begin
			// Raise the event when a request finishes, drop it once taken
			if (evt_fire) begin
				evt_valid_q <= 1'b1;
			end else if (!evt_stall) begin
				evt_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_accept) begin
						red_cnt_q <= '0;
						state_q   <= ST_EVAL;
					end
				end
				ST_EVAL: begin
					if (out_free) begin
						if (sh.hit) begin
							state_q <= ST_IDLE;
							if (stack_full) begin
								sp_q      <= SP_W'(1);
								top_q     <= '0;
								last_id_q <= '0;
							end else begin
								sp_q  <= sp_q + SP_W'(1);
								top_q <= sh.val;
								if (tok_q.token_kind == TK_ID) begin
									last_id_q <= tok_q.token_value;
								end
							end
						end else if (red_go) begin
							sp_q      <= sp_pop;
							rule_q    <= rd.val;
							popped_q  <= (pops != 2'd0);
							rd_zero_q <= (rd_ptr == '0);
							state_q   <= ST_GOTO;
						end else begin
							sp_q      <= SP_W'(1);
							top_q     <= '0;
							last_id_q <= '0;
							state_q   <= ST_IDLE;
						end
					end
				end
				ST_GOTO: begin
					if (out_free) begin
						if (gt_go) begin
							sp_q      <= sp_q + SP_W'(1);
							top_q     <= gt.val;
							red_cnt_q <= red_cnt_q + RED_W'(1);
							state_q   <= ST_EVAL;
						end else begin
							sp_q      <= SP_W'(1);
							top_q     <= '0;
							last_id_q <= '0;
							state_q   <= ST_IDLE;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Hold the token; load the event payload when a request finishes
	always_ff @(posedge clk) begin
		if (in_accept) begin
			tok_q <= tok;
		end
		if (evt_fire) begin
			evt_q <= evt_next;
		end
	end

	// Assertions
	`LRCP_ASSERT_IMPL(a_sp_range, 1'b1, (sp_q >= SP_W'(1) && sp_q <= SP_W'(STACK_DEPTH)), "stack pointer out of range")
	`LRCP_ASSERT_IMPL(a_bottom_state, (sp_q == SP_W'(1) && state_q != ST_GOTO), (top_q == '0), "bottom of stack is not state 0")
	`LRCP_ASSERT_NEXT(a_accept_eval, in_accept, (state_q == ST_EVAL), "accepted request not evaluated")
	`LRCP_ASSERT_IMPL(a_red_bound, 1'b1, (red_cnt_q <= RED_W'(MAX_RED)), "reduction count past limit")

endmodule

// ===== test/parse_event_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// parse_event_checker
// Watches the token and event channels of the configuration token parser,
// runs its own shift/reduce parse of every accepted token and compares each
// accepted event, field by field, with the oldest predicted one.
// ----------------------------------------------------------------------------
module parse_event_checker
	import lrcp_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic tok_valid,
	input  logic tok_stall,
	input  tok_t tok,
	input  logic evt_valid,
	input  logic evt_stall,
	input  evt_t evt,
	output int   mismatches,
	output int   outstanding
);

	// Grammar rules, numbered as in the parse tables
	localparam int RULE_STMTS_MORE   = 1;
	localparam int RULE_STMTS_EMPTY  = 2;
	localparam int RULE_STMT_VALUE   = 3;
	localparam int RULE_STMT_SECTION = 4;
	localparam int RULE_VALUE_INT    = 5;
	localparam int RULE_VALUE_STR    = 6;
	localparam int NO_ACTION         = -1;

	logic [ST_W-1:0] state_stack [STACK_DEPTH];
	int              depth_used;
	logic [15:0]     last_key;
	evt_t            expected_events [$];
	int              fail_total = 0;
	int              waiting = 0;

	assign mismatches  = fail_total;
	assign outstanding = waiting;

	// Next state when the token can be shifted from this state
	function automatic int shift_target(int st, tok_kind_t kind);
		int r;
		r = NO_ACTION;
		case (st)
			1: if (kind == TK_ID) r = 2;
			2: begin
				if (kind == TK_EQ) r = 4;
				else if (kind == TK_LB) r = 5;
			end
			4: begin
				if (kind == TK_INT) r = 7;
				else if (kind == TK_STR) r = 8;
			end
			6: if (kind == TK_SEMI) r = 10;
			9: begin
				if (kind == TK_RB) r = 11;
				else if (kind == TK_ID) r = 2;
			end
			default: r = NO_ACTION;
		endcase
		return r;
	endfunction

	// Rule to reduce by in this state with this lookahead
	function automatic int reduce_rule(int st, tok_kind_t kind);
		int r;
		bit closes;
		r = NO_ACTION;
		closes = (kind == TK_EOF) || (kind == TK_RB) || (kind == TK_ID);
		case (st)
			0:  if (kind == TK_EOF || kind == TK_ID) r = RULE_STMTS_EMPTY;
			3:  if (closes) r = RULE_STMTS_MORE;
			5:  if (kind == TK_RB || kind == TK_ID) r = RULE_STMTS_EMPTY;
			7:  if (kind == TK_SEMI) r = RULE_VALUE_INT;
			8:  if (kind == TK_SEMI) r = RULE_VALUE_STR;
			10: if (closes) r = RULE_STMT_VALUE;
			11: if (closes) r = RULE_STMT_SECTION;
			default: r = NO_ACTION;
		endcase
		return r;
	endfunction

	// State entered after a reduction, from the state uncovered by the pops
	function automatic int goto_target(int st, int rule);
		int r;
		r = NO_ACTION;
		case (st)
			0: if (rule == RULE_STMTS_MORE || rule == RULE_STMTS_EMPTY) r = 1;
			2: if (rule == RULE_STMT_VALUE || rule == RULE_STMT_SECTION) r = 3;
			4: if (rule == RULE_VALUE_INT || rule == RULE_VALUE_STR) r = 6;
			5: if (rule == RULE_STMTS_MORE || rule == RULE_STMTS_EMPTY) r = 9;
			default: r = NO_ACTION;
		endcase
		return r;
	endfunction

	function automatic int pop_count(int rule);
		if (rule == RULE_STMTS_MORE || rule == RULE_STMT_VALUE || rule == RULE_STMT_SECTION)
			return 3;
		if (rule == RULE_VALUE_INT || rule == RULE_VALUE_STR)
			return 1;
		return 0;
	endfunction

	// Back to the state after reset: state 0 alone on the stack
	task automatic restart_parse();
		foreach (state_stack[i]) state_stack[i] = '0;
		depth_used = 1;
		last_key   = '0;
	endtask

	// Apply reductions, then shift, accept or fail; return the event it raises
	task automatic parse_token(input tok_t t, output evt_t e);
		tok_kind_t kind;
		int        st;
		int        nxt;
		int        rule;
		int        n;
		bit        done;
		kind = tok_kind_t'(t.token_kind);
		e    = '0;
		e.event_kind = EV_SYNTAX;
		done = 1'b0;
		if (depth_used < 1 || depth_used > STACK_DEPTH) begin
			done = 1'b1;
			restart_parse();
		end
		for (n = 0; n <= MAX_RED && !done; n++) begin
			st  = int'(state_stack[depth_used - 1]);
			nxt = shift_target(st, kind);
			if (nxt != NO_ACTION) begin
				done = 1'b1;
				if (depth_used >= STACK_DEPTH) begin
					e.event_kind = EV_OVERFLOW;
					restart_parse();
				end else begin
					e.event_kind = EV_NONE;
					case (kind)
						TK_INT, TK_STR: begin
							e.event_kind   = EV_ADD;
							e.key_handle   = last_key;
							e.value_handle = t.token_value;
						end
						TK_ID: last_key = t.token_value;
						TK_LB: begin
							e.event_kind = EV_ENTER;
							e.key_handle = last_key;
						end
						TK_RB: e.event_kind = EV_LEAVE;
						default: e.event_kind = EV_NONE;
					endcase
					state_stack[depth_used] = nxt[ST_W-1:0];
					depth_used = depth_used + 1;
				end
			end else begin
				rule = reduce_rule(st, kind);
				if (rule == NO_ACTION) begin
					// Only a complete file in state 1 may see end of file
					done = 1'b1;
					if (st == 1 && kind == TK_EOF) e.event_kind = EV_ACCEPT;
					restart_parse();
				end else if (n == MAX_RED || depth_used <= pop_count(rule)) begin
					done = 1'b1;
					restart_parse();
				end else begin
					depth_used = depth_used - pop_count(rule);
					nxt = goto_target(int'(state_stack[depth_used - 1]), rule);
					if (nxt == NO_ACTION) begin
						done = 1'b1;
						restart_parse();
					end else if (depth_used >= STACK_DEPTH) begin
						done = 1'b1;
						e.event_kind = EV_OVERFLOW;
						restart_parse();
					end else begin
						state_stack[depth_used] = nxt[ST_W-1:0];
						depth_used = depth_used + 1;
					end
				end
			end
		end
		if (!done) restart_parse();
	endtask

	task automatic check_field(input string field, input logic [15:0] want,
			input logic [15:0] got);
		if (want !== got) begin
			$error("%s: expected %0h, got %0h", field, want, got);
			fail_total++;
		end
	endtask

	// Check events first: an event never belongs to a token taken in the same cycle
	always @(posedge clk or negedge arst_n) begin : monitor
		evt_t want;
		evt_t predicted;
		if (!arst_n) begin
			restart_parse();
			expected_events.delete();
			waiting = 0;
		end else begin
			if (evt_valid && !evt_stall) begin
				if (expected_events.size() == 0) begin
					$error("event_kind: expected no event, got %0d", evt.event_kind);
					fail_total++;
				end else begin
					want = expected_events.pop_front();
					check_field("event_kind", 16'(want.event_kind), 16'(evt.event_kind));
					check_field("key_handle", want.key_handle, evt.key_handle);
					check_field("value_handle", want.value_handle, evt.value_handle);
				end
			end
			if (tok_valid && !tok_stall) begin
				parse_token(tok, predicted);
				expected_events.push_back(predicted);
			end
			waiting = expected_events.size();
		end
	end

endmodule

// ===== test/tb_lr_config_token_parser.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_lr_config_token_parser
// Feeds the configuration token parser with directed token streams, then
// random configuration files (mostly well formed, some broken, some deep
// enough to overflow the stack, some noise), under changing idle and stall
// rates on both channels; the checker predicts and compares every event.
// ----------------------------------------------------------------------------
module tb_lr_config_token_parser;
	import lrcp_pkg::*;

	localparam int RANDOM_TOKENS  = 1450;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int TAIL_CYCLES    = 20;

	logic clk       = 1'b0;
	logic arst_n    = 1'b0;
	logic tok_valid = 1'b0;
	logic tok_stall;
	tok_t tok       = '0;
	logic evt_valid;
	logic evt_stall = 1'b0;
	evt_t evt;
	int   mismatches;
	int   outstanding;
	int   send_idle_pct  = 0;
	int   recv_stall_pct = 0;
	int   quiet_cycles   = 0;
	tok_t token_script [$];

	always #5 clk = ~clk;

	lr_config_token_parser u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.tok_valid (tok_valid),
		.tok_stall (tok_stall),
		.tok       (tok),
		.evt_valid (evt_valid),
		.evt_stall (evt_stall),
		.evt       (evt)
	);

	parse_event_checker u_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.tok_valid   (tok_valid),
		.tok_stall   (tok_stall),
		.tok         (tok),
		.evt_valid   (evt_valid),
		.evt_stall   (evt_stall),
		.evt         (evt),
		.mismatches  (mismatches),
		.outstanding (outstanding)
	);

	// Stall the event side at random
	always @(posedge clk) begin
		evt_stall <= ($urandom_range(0, 99) < recv_stall_pct);
	end

	// End the run when neither channel moves for too long
	always @(posedge clk) begin
		if (!arst_n || (tok_valid && !tok_stall) || (evt_valid && !evt_stall)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("FAILED: results differ");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// Mostly random handles, with the extremes now and then
	function automatic logic [15:0] pick_handle();
		logic [15:0] h;
		case ($urandom_range(0, 7))
			0:       h = 16'h0000;
			1:       h = 16'hffff;
			default: h = 16'($urandom());
		endcase
		return h;
	endfunction

	task automatic push_tok(input tok_kind_t kind, input logic [15:0] value);
		tok_t t;
		t.token_kind  = kind;
		t.token_value = value;
		token_script.push_back(t);
	endtask

	// Append one well-formed file: statements and sections, then end of file
	task automatic add_config(input int max_nest, input int stmts, input int open_pct);
		int nest;
		int left;
		nest = 0;
		left = stmts;
		while (left > 0 || nest > 0) begin
			if (left > 0 && nest < max_nest && $urandom_range(0, 99) < open_pct) begin
				push_tok(TK_ID, pick_handle());
				push_tok(TK_LB, pick_handle());
				nest++;
				left--;
			end else if (nest > 0 && (left == 0 || $urandom_range(0, 99) < 30)) begin
				push_tok(TK_RB, pick_handle());
				nest--;
			end else begin
				push_tok(TK_ID, pick_handle());
				push_tok(TK_EQ, pick_handle());
				push_tok($urandom_range(0, 1) ? TK_INT : TK_STR, pick_handle());
				push_tok(TK_SEMI, pick_handle());
				left--;
			end
		end
		push_tok(TK_EOF, pick_handle());
	endtask

	initial begin
		int   idx;
		int   total;
		int   start;
		int   mode;
		tok_t stray;

		// Empty file accepts at once
		push_tok(TK_EOF, 16'hffff);
		// Single value statement with extreme handles
		push_tok(TK_ID, 16'hffff);
		push_tok(TK_EQ, 16'h0000);
		push_tok(TK_INT, 16'h0000);
		push_tok(TK_SEMI, 16'hffff);
		push_tok(TK_EOF, 16'h0000);
		// Section holding a string value
		push_tok(TK_ID, 16'h0000);
		push_tok(TK_LB, 16'hffff);
		push_tok(TK_ID, 16'hffff);
		push_tok(TK_EQ, 16'h0000);
		push_tok(TK_STR, 16'hffff);
		push_tok(TK_SEMI, 16'h0000);
		push_tok(TK_RB, 16'hffff);
		push_tok(TK_EOF, 16'h0000);
		// Empty section
		push_tok(TK_ID, 16'h1234);
		push_tok(TK_LB, 16'h0000);
		push_tok(TK_RB, 16'h0000);
		push_tok(TK_EOF, 16'h0000);
		// Syntax errors: no action at the start, stray brace, bare identifier,
		// value right after an identifier
		push_tok(TK_SEMI, 16'h0000);
		push_tok(TK_RB, 16'hffff);
		push_tok(TK_ID, 16'h0005);
		push_tok(TK_EOF, 16'h0000);
		push_tok(TK_ID, 16'h00aa);
		push_tok(TK_INT, 16'h5555);

		// Random files until enough tokens are queued
		total = token_script.size() + RANDOM_TOKENS;
		while (token_script.size() < total) begin
			mode = $urandom_range(0, 99);
			if (mode < 60) begin
				add_config($urandom_range(0, 4), $urandom_range(0, 8), 35);
			end else if (mode < 66) begin
				// Deep nesting, around the stack limit
				add_config($urandom_range(18, 26), 60, 90);
			end else if (mode < 86) begin
				// Break one token of a good file: change, drop or cut short
				start = token_script.size();
				add_config($urandom_range(0, 3), $urandom_range(1, 6), 35);
				idx = $urandom_range(start, token_script.size() - 1);
				stray.token_kind  = TK_EOF;
				stray.token_value = pick_handle();
				case ($urandom_range(0, 2))
					0:       token_script[idx].token_kind = 3'($urandom());
					1:       token_script.delete(idx);
					default: token_script.insert(idx, stray);
				endcase
			end else begin
				repeat ($urandom_range(1, 6))
					push_tok(tok_kind_t'(3'($urandom())), pick_handle());
			end
		end

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Send every request, idling between them at the phase's rate
		total = token_script.size();
		for (idx = 0; idx < total; idx++) begin
			if (idx < total / 3) begin
				send_idle_pct  = 18;
				recv_stall_pct = 47;
			end else if (idx < 2 * total / 3) begin
				send_idle_pct  = 47;
				recv_stall_pct = 18;
			end else begin
				send_idle_pct  = 0;
				recv_stall_pct = 0;
			end
			while ($urandom_range(0, 99) < send_idle_pct) begin
				tok_valid <= 1'b0;
				@(posedge clk);
			end
			tok_valid <= 1'b1;
			tok       <= token_script[idx];
			// Hold the request until the edge that takes it
			do @(negedge clk); while (tok_stall);
			@(posedge clk);
		end
		tok_valid <= 1'b0;

		// Drain, then watch a little longer for stray events
		do @(negedge clk); while (outstanding != 0);
		repeat (TAIL_CYCLES) @(negedge clk);
		if (mismatches == 0 && outstanding == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule

// ===== lr_config_token_parser.f =====
+incdir+rtl/core
rtl/core/lrcp_pkg.sv
rtl/core/lrcp_ram.sv
rtl/core/lr_config_token_parser.sv
test/parse_event_checker.sv
test/tb_lr_config_token_parser.sv
